[src/ssms_pkg.sv]
// ============================================================================
// Sorted sparse matrix store - shared package
// Default sizes, beat layouts, result status codes and register indexes.
// ============================================================================
package ssms_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int MAX_DIM_DEF  = 1024;

    localparam int IDX_W  = 10;   // row and column index width
    localparam int VAL_W  = 32;   // element value width
    localparam int DIM_W  = 11;   // num_rows / num_cols register width
    localparam int OCC_W  = 9;    // occupancy field width
    localparam int KEY_W  = 2 * IDX_W;
    localparam int ENT_W  = KEY_W + VAL_W;

    // Input beat: tdata = row, col, value (lowest first), tuser = op
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 1;
    // Output beat: tdata = data, occupancy (lowest first), tuser = status
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register indexes (paddr[2])
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_MISS  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_entry;

endpackage

[src/sorted_sparse_matrix_store.sv]
// ============================================================================
// Sorted sparse matrix store - top level
// Coordinate-list store of (row, column, value) triplets in row-major order.
// ============================================================================
// The block handles one beat at a time. A beat whose indices fall outside the
// configured dimensions or MAX_DIM skips the search and goes straight to
// S_FINISH, which loads its result into the output register. Any other beat
// first runs a binary search over the stored triplets in the single RAM: each
// halving step issues the read (S_SEARCH) and compares the registered data
// (S_PROBE). An insertion then moves every later triplet up by one entry, one
// per cycle through the RAM's single read and write port, and writes the new
// triplet into the gap. The result waits in an output register, and the block
// takes the next beat as soon as it has handed its result over to that
// register. Configuration must only be written while the block is idle. The RAM
// needs no clearing after reset, as only entries below the live count are ever
// used.
// ============================================================================
module sorted_sparse_matrix_store #(
    parameter int CAPACITY = ssms_pkg::CAPACITY_DEF,
    parameter int MAX_DIM  = ssms_pkg::MAX_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input beats
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // row [9:0], col [19:10], value [51:20], zero [55:52]
    input  logic [ssms_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // op [0]
    input  logic [ssms_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    // Result beats
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // data [31:0], occupancy [40:32], zero [47:41]
    output logic [ssms_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // status [1:0]
    output logic [ssms_pkg::M_TUSER_W-1:0] o_m_axis_tuser,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ssms_pkg::APB_AW-1:0]    paddr,
    input  logic [ssms_pkg::APB_DW-1:0]    pwdata,
    output logic [ssms_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    import ssms_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_PROBE  = 6'b000100,
        S_CHECK  = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    // Control state
    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [DIM_W-1:0] r_num_rows, r_num_cols;
    logic             r_out_valid, n_out_valid;
    logic             r_pend, n_pend;

    // Working registers of the current beat
    logic             r_op, n_op;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic [VAL_W-1:0] r_value, n_value;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_mid, n_mid;
    logic [CW-1:0]    r_k, n_k;
    logic [AW-1:0]    r_wa, n_wa;
    logic [VAL_W-1:0] r_res_data, n_res_data;
    t_status          r_res_status, n_res_status;

    // Output register
    logic [VAL_W-1:0] r_out_data, n_out_data;
    t_status          r_out_status, n_out_status;
    logic [OCC_W-1:0] r_out_occ, n_out_occ;

    // Memory port
    logic             ram_we;
    logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
    t_entry           ram_wr_data, ram_rd_data;

    logic             s_accept;
    logic [IDX_W-1:0] in_row, in_col;
    logic [VAL_W-1:0] in_value;
    logic             in_range_bad;
    logic [KEY_W-1:0] key, rd_key;
    logic [CW-1:0]    mid_c;
    logic             found;
    logic             cfg_write;

    ssms_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Beat unpacking
    assign in_row   = i_s_axis_tdata[IDX_W-1:0];
    assign in_col   = i_s_axis_tdata[2*IDX_W-1:IDX_W];
    assign in_value = i_s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // An index is out of range against the configured size and the hard limit.
    assign in_range_bad = ({1'b0, in_row} >= r_num_rows) || ({1'b0, in_col} >= r_num_cols) ||
                          (32'(in_row) >= 32'(MAX_DIM)) || (32'(in_col) >= 32'(MAX_DIM));

    // Row-major key: row in the upper half, so plain unsigned compare orders it.
    assign key    = {r_row, r_col};
    assign rd_key = {ram_rd_data.row, ram_rd_data.col};
    assign mid_c  = r_lo + ((r_hi - r_lo) >> 1);
    assign found  = (r_lo < r_count) && (rd_key == key);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_pend       = r_pend;
        n_op         = r_op;
        n_row        = r_row;
        n_col        = r_col;
        n_value      = r_value;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_k          = r_k;
        n_wa         = r_wa;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_occ    = r_out_occ;

        ram_we       = 1'b0;
        ram_wr_addr  = r_wa;
        ram_wr_data  = ram_rd_data;
        ram_rd_addr  = r_lo[AW-1:0];

        // The consumer drains the output register independently of the search.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_op    = i_s_axis_tuser[0];
                    n_row   = in_row;
                    n_col   = in_col;
                    n_value = in_value;
                    n_lo    = '0;
                    n_hi    = r_count;
                    if (in_range_bad) begin
                        n_res_data   = '0;
                        n_res_status = ST_RANGE;
                        n_state      = S_FINISH;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    ram_rd_addr = mid_c[AW-1:0];
                    n_mid       = mid_c;
                    n_state     = S_PROBE;
                end else begin
                    // Search has converged; fetch the candidate at the lower bound.
                    ram_rd_addr = r_lo[AW-1:0];
                    n_state     = S_CHECK;
                end
            end
            S_PROBE: begin
                if (rd_key < key) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SEARCH;
            end
            S_CHECK: begin
                n_res_data = '0;
                n_state    = S_FINISH;
                if (found) begin
                    n_res_data   = ram_rd_data.value;
                    n_res_status = ST_FOUND;
                    if (r_op == OP_WRITE) begin
                        ram_we      = 1'b1;
                        ram_wr_addr = r_lo[AW-1:0];
                        ram_wr_data = '{row: r_row, col: r_col, value: r_value};
                    end
                end else if (r_op == OP_READ) begin
                    n_res_status = ST_MISS;
                end else if (r_count == CW'(CAPACITY)) begin
                    n_res_status = ST_FULL;
                end else begin
                    n_res_status = ST_MISS;
                    n_k          = r_count;
                    n_pend       = 1'b0;
                    n_state      = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // Read entry k-1 while the entry read last cycle is written one up.
                if (r_k > r_lo) begin
                    ram_rd_addr = AW'(r_k - CW'(1));
                    n_wa        = r_k[AW-1:0];
                    n_k         = r_k - CW'(1);
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    ram_we      = 1'b1;
                    ram_wr_addr = r_wa;
                    ram_wr_data = ram_rd_data;
                end else if (r_k == r_lo) begin
                    ram_we      = 1'b1;
                    ram_wr_addr = r_lo[AW-1:0];
                    ram_wr_data = '{row: r_row, col: r_col, value: r_value};
                    n_count     = r_count + CW'(1);
                    n_state     = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_res_data;
                    n_out_status = r_res_status;
                    n_out_occ    = OCC_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration registers
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_NUM_ROWS: prdata = APB_DW'(r_num_rows);
            REG_NUM_COLS: prdata = APB_DW'(r_num_cols);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_num_rows  <= DIM_W'(1);
            r_num_cols  <= DIM_W'(1);
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            if (cfg_write && (paddr[2] == REG_NUM_ROWS)) begin
                r_num_rows <= pwdata[DIM_W-1:0];
            end
            if (cfg_write && (paddr[2] == REG_NUM_COLS)) begin
                r_num_cols <= pwdata[DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_row        <= n_row;
        r_col        <= n_col;
        r_value      <= n_value;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_k          <= n_k;
        r_wa         <= n_wa;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_occ    <= n_out_occ;
    end

    // Result beat packing
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'({r_out_occ, r_out_data});
    assign o_m_axis_tuser  = r_out_status;

endmodule

[src/ssms_ram.sv]
// ============================================================================
// Sorted sparse matrix store - generic RAM
// One write port and one read port, read data registered.
// ============================================================================
module ssms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

[src/ssms_checker.sv]
// ============================================================================
// Sorted sparse matrix store - port checker
// Watches the top level's ports and flags results that break its contract.
// ============================================================================
module ssms_checker #(
    parameter int CAPACITY = ssms_pkg::CAPACITY_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [ssms_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input logic [ssms_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);

    import ssms_pkg::*;

    // A held result beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    // The block works on one beat at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while a beat is in progress");

    // Absent, rejected and out-of-range results carry zero data.
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != M_TUSER_W'(ST_FOUND)) |->
            (o_m_axis_tdata[VAL_W-1:0] == '0))
        else $error("non-zero data on a result without a stored entry");

    // A write is only refused as full when the table really is full.
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == M_TUSER_W'(ST_FULL)) |->
            (o_m_axis_tdata[VAL_W+OCC_W-1:VAL_W] == OCC_W'(CAPACITY)))
        else $error("table full reported below capacity");

endmodule

bind sorted_sparse_matrix_store ssms_checker #(.CAPACITY(CAPACITY)) u_ssms_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
